/* sv/bsa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 8;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted_slot;
    logic [STATUS_W-1:0] status;
    logic                became_empty;
    logic [LIVE_W-1:0]   live_now;
    logic                overflow_first;
  } bsa_result_t;

endpackage

/* sv/bsa_if.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces of the slot allocator.
interface bsa_req_if;
  import bsa_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, kind, slot, input ready);
  modport sink   (input valid, kind, slot, output ready);
endinterface

interface bsa_rsp_if;
  import bsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   granted_slot;
  logic [STATUS_W-1:0] status;
  logic                became_empty;
  logic [LIVE_W-1:0]   live_now;
  logic                overflow_first;

  modport source (output valid, granted_slot, status, became_empty, live_now,
                  overflow_first, input ready);
  modport sink   (input valid, granted_slot, status, became_empty, live_now,
                  overflow_first, output ready);
endinterface

/* sv/bsa_lowest_free.sv */
`timescale 1ns / 1ps
// Lowest-set-bit finder: one-hot of the lowest free slot and its index.
module bsa_lowest_free #(
  parameter int N     = 64,
  parameter int IDX_W = 6
) (
  input  logic [N-1:0]     free,
  output logic             found,
  output logic [N-1:0]     onehot,
  output logic [IDX_W-1:0] idx
);

  // x & -x isolates the lowest set bit
  assign onehot = free & (~free + N'(1));
  assign found  = |free;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

endmodule

/* sv/bsa_rsp_reg.sv */
`timescale 1ns / 1ps
// Response output register; frees up when the beat is taken downstream.
module bsa_rsp_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  bsa_pkg::bsa_result_t data,
  output logic                 can_load,
  bsa_rsp_if.source            rsp
);
  import bsa_pkg::*;

  logic        valid;
  bsa_result_t held;

  assign can_load = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign rsp.valid          = valid;
  assign rsp.granted_slot   = held.granted_slot;
  assign rsp.status         = held.status;
  assign rsp.became_empty   = held.became_empty;
  assign rsp.live_now       = held.live_now;
  assign rsp.overflow_first = held.overflow_first;

endmodule

/* sv/bitmap_slot_allocator.sv */
`timescale 1ns / 1ps
// Bitmap slot allocator: grants the lowest free slot, takes slots back.
//
// req carries kind (acquire or release) and slot (release only). rsp carries
// one beat per request: granted slot, status, empty flag, live count and the
// one-time overflow warning.
// An accepted request is resolved in the cycle it is taken: occupancy maps,
// live count and warning flag update at that edge and the response sits in
// the output register from the next cycle. One request is taken every cycle
// while req.ready is high; the cycle is set by the lowest-free-slot search
// across the base and overflow bitmaps.
// req.ready is high while the output register is empty or being drained, so
// a stalled receiver holds at most one response and then backpressures req.
// Reset clears both bitmaps, the live count, the warning flag and the
// output valid; the block takes requests in the first cycle after reset.
// Overflow slots numbered 128 and up can be granted (the number wraps to 7
// bits) but can never be released.
module bitmap_slot_allocator #(
  parameter int BASE_SLOTS     = 64,
  parameter int OVERFLOW_SLOTS = 64
) (
  input  logic    clk,
  input  logic    rst,
  bsa_req_if.sink req,
  bsa_rsp_if.source rsp
);
  import bsa_pkg::*;

  localparam int OVF_N      = (OVERFLOW_SLOTS > 0) ? OVERFLOW_SLOTS : 1;
  localparam int BASE_IDX_W = (BASE_SLOTS > 1) ? $clog2(BASE_SLOTS) : 1;
  localparam int OVF_IDX_W  = (OVF_N > 1) ? $clog2(OVF_N) : 1;
  localparam int CNT_W      = $clog2(BASE_SLOTS + OVERFLOW_SLOTS + 1);
  localparam logic [OVF_N-1:0] OVF_MASK = {OVF_N{OVERFLOW_SLOTS > 0}};

  logic [BASE_SLOTS-1:0] base_map, base_map_next;
  logic [OVF_N-1:0]      ovf_map, ovf_map_next;
  logic [CNT_W-1:0]      live_total, live_total_next;
  logic                  warned, warned_next;

  logic                  base_found, ovf_found;
  logic [BASE_SLOTS-1:0] base_onehot;
  logic [OVF_N-1:0]      ovf_onehot;
  logic [BASE_IDX_W-1:0] base_idx;
  logic [OVF_IDX_W-1:0]  ovf_idx;

  logic                  rel_in_base, rel_in_ovf, rel_ok;
  logic [SLOT_W-1:0]     rel_j;
  logic [BASE_IDX_W-1:0] rel_base_idx;
  logic [OVF_IDX_W-1:0]  rel_ovf_idx;

  logic                  accept, can_load;
  bsa_result_t           res;

  bsa_lowest_free #(.N(BASE_SLOTS), .IDX_W(BASE_IDX_W)) u_base_find (
    .free   (~base_map),
    .found  (base_found),
    .onehot (base_onehot),
    .idx    (base_idx)
  );

  bsa_lowest_free #(.N(OVF_N), .IDX_W(OVF_IDX_W)) u_ovf_find (
    .free   (~ovf_map & OVF_MASK),
    .found  (ovf_found),
    .onehot (ovf_onehot),
    .idx    (ovf_idx)
  );

  assign req.ready = can_load;
  assign accept    = req.valid && can_load;

  // release decode; out-of-range bits are masked by the range checks
  assign rel_in_base  = 32'(req.slot) < BASE_SLOTS;
  assign rel_j        = req.slot - SLOT_W'(BASE_SLOTS);
  assign rel_in_ovf   = !rel_in_base && (32'(rel_j) < OVERFLOW_SLOTS);
  assign rel_base_idx = BASE_IDX_W'(req.slot);
  assign rel_ovf_idx  = OVF_IDX_W'(rel_j);
  assign rel_ok = (live_total != '0) &&
                  ((rel_in_base && base_map[rel_base_idx]) ||
                   (rel_in_ovf && ovf_map[rel_ovf_idx]));

  always_comb begin
    base_map_next   = base_map;
    ovf_map_next    = ovf_map;
    live_total_next = live_total;
    warned_next     = warned;
    res.granted_slot   = '0;
    res.status         = STATUS_OK;
    res.became_empty   = 1'b0;
    res.overflow_first = 1'b0;
    if (req.kind == KIND_ACQUIRE) begin
      if (base_found) begin
        base_map_next    = base_map | base_onehot;
        live_total_next  = live_total + CNT_W'(1);
        res.granted_slot = SLOT_W'(base_idx);
      end else if (ovf_found) begin
        ovf_map_next       = ovf_map | ovf_onehot;
        live_total_next    = live_total + CNT_W'(1);
        res.granted_slot   = SLOT_W'(BASE_SLOTS) + SLOT_W'(ovf_idx);
        warned_next        = 1'b1;
        res.overflow_first = !warned;
      end else begin
        res.status = STATUS_FULL;
      end
    end else begin
      if (rel_ok) begin
        if (rel_in_base) begin
          base_map_next = base_map & ~(BASE_SLOTS'(1) << rel_base_idx);
        end else begin
          ovf_map_next = ovf_map & ~(OVF_N'(1) << rel_ovf_idx);
        end
        live_total_next  = live_total - CNT_W'(1);
        res.became_empty = (live_total == CNT_W'(1));
      end else begin
        res.status = STATUS_NOT_LIVE;
      end
    end
    res.live_now = LIVE_W'(live_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_map   <= '0;
      ovf_map    <= '0;
      live_total <= '0;
      warned     <= 1'b0;
    end else if (accept) begin
      base_map   <= base_map_next;
      ovf_map    <= ovf_map_next;
      live_total <= live_total_next;
      warned     <= warned_next;
    end
  end

  bsa_rsp_reg u_rsp_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .data     (res),
    .can_load (can_load),
    .rsp      (rsp)
  );

endmodule

/* sv/bsa_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the allocator response channel, bound to the top.
module bsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [bsa_pkg::SLOT_W-1:0]    granted_slot,
  input logic [bsa_pkg::STATUS_W-1:0]  status,
  input logic                          became_empty,
  input logic [bsa_pkg::LIVE_W-1:0]    live_now,
  input logic                          overflow_first
);
  import bsa_pkg::*;

  logic seen_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first <= 1'b0;
    end else if (rsp_valid && rsp_ready && overflow_first) begin
      seen_first <= 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  a_first_once: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && overflow_first |-> !seen_first)
    else $error("overflow warning raised twice");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STATUS_OK |->
      granted_slot == '0 && !became_empty && !overflow_first)
    else $error("failed beat carries grant or flags");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && became_empty |-> live_now == '0 && status == STATUS_OK)
    else $error("empty flag with live slots");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .granted_slot   (rsp.granted_slot),
  .status         (rsp.status),
  .became_empty   (rsp.became_empty),
  .live_now       (rsp.live_now),
  .overflow_first (rsp.overflow_first)
);
